// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, also while reset is high.
`define PHE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check a property on every rising edge outside reset.
`define PHE_ASSERT_RUN(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// File: rtl/core/phe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package phe_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_COUNT = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam int unsigned OUT_COUNT_W = 32;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] bin_value;
  } phe_in_t;

  typedef struct packed {
    logic [7:0]             bin_index;
    logic [OUT_COUNT_W-1:0] bin_count;
  } phe_out_t;

  // Handshake control from the top level into the update stage.
  typedef struct packed {
    logic accept;
    logic advance;
  } phe_ctl_t;

  // Update stage status back to the top level.
  typedef struct packed {
    logic busy;
    logic has_result;
  } phe_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/pixel_histogram_engine_unit.sv
// A read result passes from the update stage into the output register.
// Throughput: one item per cycle unless stalled, set by the single count memory
// read-modify-write loop; a previous item's write is forwarded to a following hit.
// Clear drops all bin valid marks at once; no clearing pass is needed.
// Reset (rst, synchronous, active high) empties the pipeline and all bins.
`timescale 1ns / 1ps
`default_nettype none

module pixel_histogram_engine_unit import phe_pkg::*; #(
  parameter int unsigned NUM_BINS    = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     pix_valid,
  output logic          pix_ready,
  input  wire phe_in_t  pix,
  output logic          res_valid,
  input  wire logic     res_ready,
  output phe_out_t      res
);

  phe_ctl_t  ctl;
  phe_stat_t stat;
  phe_out_t  rmw_result;

  // Advance the update stage unless it holds a read and the output is full.
  assign ctl.advance = stat.busy && (!stat.has_result || !res_valid || res_ready);
  // Take a new item whenever the update stage is empty or moving on.
  assign pix_ready   = !stat.busy || ctl.advance;
  assign ctl.accept  = pix_valid && pix_ready;

  // Stage one: memory read issued at accept, modify and write back when the stage advances.
  phe_rmw #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_rmw (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .req    (pix),
    .stat   (stat),
    .result (rmw_result)
  );

  // Output register: load a read result, drop the valid once the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.advance && stat.has_result) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Hold the payload until a new result replaces it.
  always_ff @(posedge clk) begin
    if (ctl.advance && stat.has_result) begin
      res <= rmw_result;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/phe_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module phe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read before write on a shared address; hold read data while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/phe_rmw.sv
`timescale 1ns / 1ps
`default_nettype none

module phe_rmw import phe_pkg::*; #(
  parameter int unsigned NUM_BINS    = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire phe_ctl_t  ctl,
  input  wire phe_in_t   req,
  output phe_stat_t      stat,
  output phe_out_t       result
);

  localparam int unsigned IDX_W     = $clog2(NUM_BINS);
  localparam logic [8:0]  BIN_LIMIT = 9'(NUM_BINS);

  logic                   s1_valid;
  logic [1:0]             s1_type;
  logic [7:0]             s1_value;
  logic                   s1_fwd;
  logic [COUNT_WIDTH-1:0] s1_fwd_data;

  logic [NUM_BINS-1:0]    valid_bits;
  logic [COUNT_WIDTH-1:0] ram_q;

  logic                   s1_in_range;
  logic [IDX_W-1:0]       s1_idx;
  logic                   bin_live;
  logic [COUNT_WIDTH-1:0] old_count;
  logic [COUNT_WIDTH-1:0] new_count;
  logic [63:0]            wide_count;

  logic                   wr_en;
  logic [IDX_W-1:0]       rd_addr;

  assign s1_in_range = ({1'b0, s1_value} < BIN_LIMIT);
  assign s1_idx      = s1_value[IDX_W-1:0];
  assign rd_addr     = req.bin_value[IDX_W-1:0];

  // A bin whose valid mark is down reads as empty.
  assign bin_live  = s1_in_range && valid_bits[s1_idx];
  assign old_count = bin_live ? (s1_fwd ? s1_fwd_data : ram_q) : '0;
  assign new_count = (old_count == '1) ? old_count : old_count + COUNT_WIDTH'(1);

  assign wr_en = ctl.advance && s1_valid && (s1_type == REQ_COUNT) && s1_in_range;

  phe_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_counts (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_idx),
    .wdata (new_count),
    .re    (ctl.accept),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ctl.accept) begin
      s1_valid <= 1'b1;
    end else if (ctl.advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the item and note whether the write in flight hits the same bin.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      s1_type     <= req.req_type;
      s1_value    <= req.bin_value;
      s1_fwd      <= wr_en && (s1_idx == rd_addr);
      s1_fwd_data <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (ctl.advance && s1_valid && (s1_type == REQ_CLEAR)) begin
      valid_bits <= '0;
    end else if (wr_en) begin
      valid_bits[s1_idx] <= 1'b1;
    end
  end

  assign stat.busy       = s1_valid;
  assign stat.has_result = s1_valid && (s1_type == REQ_READ);

  // Clamp the count to the output width.
  assign wide_count       = 64'(old_count);
  assign result.bin_index = s1_value;
  assign result.bin_count = (wide_count[63:OUT_COUNT_W] != '0) ? '1
                                                               : wide_count[OUT_COUNT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/phe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module phe_checker import phe_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     pix_ready,
  input wire logic     res_valid,
  input wire logic     res_ready,
  input wire phe_out_t res
);

  `PHE_ASSERT_ALWAYS(a_empty_after_rst, clk, rst |=> !res_valid, "result after reset")
  `PHE_ASSERT_ALWAYS(a_ready_after_rst, clk, rst |=> pix_ready, "not ready after reset")
  `PHE_ASSERT_RUN(a_stall_needs_full, clk, rst, !pix_ready |-> res_valid, "stall without result")
  `PHE_ASSERT_RUN(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res), "result dropped")

endmodule

bind pixel_histogram_engine_unit phe_checker u_chk (.*);

`default_nettype wire
